// ----- design/assert_macros.svh -----
// Assertion macros, included by servo_pair_pulse_scheduler.
// Clock and reset are taken from the including module (clk, rst).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/spps_pkg.sv -----
// Shared types and constants of the servo pair pulse scheduler.
// No dependencies.
package spps_pkg;

  localparam int CH_W      = 4;
  localparam int NUM_CH    = 16;
  localparam int PAIR_W    = 3;
  localparam int US_W      = 16;
  localparam int RATE_W    = 20;
  localparam int PROD_W    = US_W + RATE_W;
  localparam int TICK_W    = 10;
  localparam int MASK_W    = 8;
  localparam int WAIT_W    = 8;
  localparam int SLOT_W    = 6;
  localparam int NUM_SLOTS = 5;
  localparam int K_W       = 3;

  localparam logic [63:0] US_PER_S = 64'd1000000;

  // floor(p / 1e6) as (p * RECIP) >> RECIP_SHIFT, exact for p < 2^30
  localparam int RECIP_IN_W  = 30;
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 50;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_SHIFT) + US_PER_S - 64'd1) / US_PER_S;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  // a disabled channel behaves as a 200-tick pulse with no port bit
  localparam logic [TICK_W-1:0] DISABLED_TICKS = 10'd200;

  localparam logic [MASK_W-1:0] PIN_BIT [NUM_CH] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h20, 8'h10
  };

  typedef struct packed {
    logic [TICK_W-1:0] x_lo;
    logic [TICK_W-1:0] x_hi;
    logic [MASK_W-1:0] k_lo;
    logic [MASK_W-1:0] k_hi;
  } pair_t;

  typedef struct packed {
    logic [WAIT_W-1:0] wait_ticks;
    logic [MASK_W-1:0] mask_a;
    logic [WAIT_W-1:0] delay_units;
    logic [MASK_W-1:0] mask_b;
  } slot_t;

endpackage

// ----- design/spps_layout.sv -----
// Builds the five timing slots of one channel pair from its sorted pulses.
// Depends on spps_pkg.
module spps_layout (
  input  spps_pkg::pair_t                           pair,
  output spps_pkg::slot_t [spps_pkg::NUM_SLOTS-1:0] slots
);
  import spps_pkg::*;

  logic [TICK_W-1:0] d;
  logic [TICK_W-1:0] rest;
  logic [TICK_W-1:0] lead;
  logic [MASK_W-1:0] both;
  logic [K_W-1:0]    c;
  logic [TICK_W-1:0] w  [NUM_SLOTS];
  logic [MASK_W-1:0] m0 [NUM_SLOTS];
  logic [WAIT_W-1:0] p1 [NUM_SLOTS];
  logic [MASK_W-1:0] m1 [NUM_SLOTS];

  always_comb begin
    d    = pair.x_hi - pair.x_lo;
    rest = 10'd600 - pair.x_hi;
    lead = (pair.x_lo > 10'd220) ? 10'd210 : 10'd10;
    both = pair.k_lo | pair.k_hi;
    c    = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      w[i]  = '0;
      m0[i] = 8'hFF;
      p1[i] = '0;
      m1[i] = 8'hFF;
    end
    m0[0] = both;

    if (d < 10'd2) begin
      // pulses (nearly) coincide: one slot clears both pins
      if (pair.x_lo > 10'd400) begin
        c = 3'd3;
        w[0] = 10'd190;
        w[1] = 10'd190;
        w[2] = pair.x_lo - 10'd380;
        w[3] = 10'd590 - pair.x_lo;
        w[4] = 10'd10;
      end else if (pair.x_lo > 10'd200) begin
        c = 3'd2;
        w[0] = 10'd190;
        w[1] = pair.x_lo - 10'd190;
        w[2] = 10'd90;
        w[3] = 10'd420 - pair.x_lo;
        w[4] = 10'd90;
      end else begin
        c = 3'd1;
        w[0] = pair.x_lo;
        w[1] = 10'd250 - pair.x_lo;
        w[2] = 10'd100;
        w[3] = 10'd150;
        w[4] = 10'd100;
      end
      if (d == '0) begin
        m0[c] = ~both;
      end else begin
        m0[c] = ~pair.k_lo;
        p1[c] = d[WAIT_W-1:0];
        m1[c] = ~pair.k_hi;
      end
    end else if (d > 10'd235) begin
      w[0] = 10'd110;
      w[1] = pair.x_lo - 10'd110;
      w[2] = 10'd230;
      w[3] = d - 10'd230;
      w[4] = rest;
      m0[2] = ~pair.k_lo;
      m0[4] = ~pair.k_hi;
    end else if (pair.x_lo > 10'd440) begin
      w[0] = 10'd210;
      w[1] = 10'd210;
      w[2] = pair.x_lo - 10'd420;
      w[3] = d;
      w[4] = rest;
      m0[3] = ~pair.k_lo;
      m0[4] = ~pair.k_hi;
    end else begin
      w[0] = lead;
      w[1] = pair.x_lo - lead;
      w[2] = d;
      w[3] = rest >> 1;
      w[4] = rest - (rest >> 1);
      m0[2] = ~pair.k_lo;
      m0[3] = ~pair.k_hi;
    end

    for (int i = 0; i < NUM_SLOTS; i++) begin
      slots[i] = '{w[i][WAIT_W-1:0], m0[i], p1[i], m1[i]};
    end
  end

endmodule

// ----- design/servo_pair_pulse_scheduler.sv -----
// Servo pair pulse scheduler: a width write in, five schedule slot words out.
// Users of the block:
//  - cmd channel (cmd_valid/cmd_stall): one word = channel and pulse width in us.
//    Width 0 disables the channel. Channels above TOP_CHANNEL are taken and
//    dropped with no effect and no output.
//  - sched channel (sched_valid/sched_stall): five words per kept command, slots
//    5p..5p+4 of the channel's pair p, in order; last marks the fifth word.
//  - The first slot word appears once the command has passed the product,
//    divide/clamp, store/sort and layout stages, then one word per cycle while
//    sched_stall is low; the single-word output port limits the command rate, and
//    the four front stages keep taking commands while slot words drain.
//  - Stalling the sched channel holds the current word and fills the front
//    stages; cmd_stall rises once they are full.
//  - Reset clears all stored widths and enables and empties the pipeline.
// Depends on spps_pkg, spps_layout and assert_macros.svh.
`include "assert_macros.svh"

module servo_pair_pulse_scheduler #(
  parameter int TOP_CHANNEL  = 15,
  parameter int TICK_RATE_HZ = 230400,
  parameter int MIN_TICKS    = 115,
  parameter int MAX_TICKS    = 576
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [spps_pkg::CH_W-1:0]     channel,
  input  logic [spps_pkg::US_W-1:0]     pulse_width_us,
  output logic                          sched_valid,
  input  logic                          sched_stall,
  output logic [spps_pkg::SLOT_W-1:0]   slot,
  output logic [spps_pkg::WAIT_W-1:0]   first_wait,
  output logic [spps_pkg::MASK_W-1:0]   first_mask,
  output logic [spps_pkg::WAIT_W-1:0]   second_wait,
  output logic [spps_pkg::MASK_W-1:0]   second_mask,
  output logic [spps_pkg::NUM_CH-1:0]   enabled_channels,
  output logic                          last
);
  import spps_pkg::*;

  localparam logic [CH_W-1:0]   TOP_CH = CH_W'(TOP_CHANNEL);
  localparam logic [PROD_W-1:0] RATE   = PROD_W'(TICK_RATE_HZ);
  localparam logic [TICK_W-1:0] MIN_T  = TICK_W'(MIN_TICKS);
  localparam logic [TICK_W-1:0] MAX_T  = TICK_W'(MAX_TICKS);
  localparam logic [PROD_W-1:0] LO_LIM = PROD_W'(64'(MIN_TICKS) * US_PER_S);
  localparam logic [PROD_W-1:0] HI_LIM = PROD_W'((64'(MAX_TICKS) + 64'd1) * US_PER_S);
  localparam logic [K_W-1:0]    K_LAST = K_W'(NUM_SLOTS - 1);

  // pipeline valids and handshake
  logic s1_v, s2_v, s3_v, s4_v, buf_v;
  logic s1_go, s2_go, s3_go, s4_go;
  logic s1_free, s2_free, s3_free, s4_free, buf_free;
  logic cmd_fire, out_fire, buf_done;

  // stage payloads
  logic [CH_W-1:0]   s1_ch;
  logic [US_W-1:0]   s1_us;
  logic [CH_W-1:0]   s2_ch;
  logic              s2_en;
  logic [PROD_W-1:0] s2_prod;
  logic [CH_W-1:0]   s3_ch;
  logic              s3_en;
  logic [TICK_W-1:0] s3_tick;
  pair_t             s4_pair;
  logic [SLOT_W-1:0] s4_base;
  logic [NUM_CH-1:0] s4_en;

  // channel state
  logic [TICK_W-1:0] chan_ticks [NUM_CH];
  logic [NUM_CH-1:0] chan_en;

  // output buffer
  slot_t [NUM_SLOTS-1:0] buf_slots;
  logic [SLOT_W-1:0]     buf_base;
  logic [NUM_CH-1:0]     buf_en;
  logic [K_W-1:0]        k;

  // combinational
  logic [RECIP_IN_W+RECIP_W-1:0] quot_full;
  logic [TICK_W-1:0]             tick_next;
  logic [CH_W-1:0]               partner;
  logic [TICK_W-1:0]             own_x, oth_x, xa, xb;
  logic [MASK_W-1:0]             own_k, oth_k, ka, kb;
  pair_t                         pair_next;
  logic [NUM_CH-1:0]             en_next;
  slot_t [NUM_SLOTS-1:0]         lay_slots;
  slot_t                         cur;

  always_comb begin
    out_fire = buf_v && !sched_stall;
    buf_done = out_fire && (k == K_LAST);
    buf_free = !buf_v || buf_done;
    s4_go    = s4_v && buf_free;
    s4_free  = !s4_v || s4_go;
    s3_go    = s3_v && s4_free;
    s3_free  = !s3_v || s3_go;
    s2_go    = s2_v && s3_free;
    s2_free  = !s2_v || s2_go;
    s1_go    = s1_v && s2_free;
    s1_free  = !s1_v || s1_go;
    cmd_stall = !s1_free;
    cmd_fire  = cmd_valid && !cmd_stall;
  end

  // ticks = width * rate / 1e6, clamped; the reciprocal path is exact in range
  always_comb begin
    quot_full = (RECIP_IN_W+RECIP_W)'(s2_prod[RECIP_IN_W-1:0]) *
                (RECIP_IN_W+RECIP_W)'(RECIP);
    if (s2_prod < LO_LIM) begin
      tick_next = MIN_T;
    end else if (s2_prod >= HI_LIM) begin
      tick_next = MAX_T;
    end else begin
      tick_next = quot_full[RECIP_SHIFT +: TICK_W];
    end
  end

  // pair lookup with the fresh value of the written channel, then sort
  always_comb begin
    partner = {s3_ch[CH_W-1:1], ~s3_ch[0]};
    own_x   = s3_en ? s3_tick : DISABLED_TICKS;
    own_k   = s3_en ? PIN_BIT[s3_ch] : '0;
    oth_x   = chan_en[partner] ? chan_ticks[partner] : DISABLED_TICKS;
    oth_k   = chan_en[partner] ? PIN_BIT[partner] : '0;
    if (!s3_ch[0]) begin
      xa = own_x; ka = own_k; xb = oth_x; kb = oth_k;
    end else begin
      xa = oth_x; ka = oth_k; xb = own_x; kb = own_k;
    end
    if (xa > xb) begin
      pair_next = '{xb, xa, kb, ka};
    end else begin
      pair_next = '{xa, xb, ka, kb};
    end
    en_next        = chan_en;
    en_next[s3_ch] = s3_en;
  end

  spps_layout u_layout (
    .pair  (s4_pair),
    .slots (lay_slots)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      buf_v <= 1'b0;
      k     <= '0;
      chan_en <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        chan_ticks[i] <= '0;
      end
    end else begin
      if (s1_free) s1_v <= cmd_fire && (channel <= TOP_CH);
      if (s2_free) s2_v <= s1_v;
      if (s3_free) s3_v <= s2_v;
      if (s4_free) s4_v <= s3_v;
      if (buf_free) buf_v <= s4_v;
      if (buf_done) begin
        k <= '0;
      end else if (out_fire) begin
        k <= k + 1'b1;
      end
      if (s3_go) begin
        chan_en           <= en_next;
        chan_ticks[s3_ch] <= s3_tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_ch <= channel;
      s1_us <= pulse_width_us;
    end
    if (s1_go) begin
      s2_ch   <= s1_ch;
      s2_en   <= (s1_us != '0);
      s2_prod <= PROD_W'(s1_us) * RATE;
    end
    if (s2_go) begin
      s3_ch   <= s2_ch;
      s3_en   <= s2_en;
      s3_tick <= tick_next;
    end
    if (s3_go) begin
      s4_pair <= pair_next;
      s4_base <= SLOT_W'({s3_ch[CH_W-1:1], 2'b00}) + SLOT_W'(s3_ch[CH_W-1:1]);
      s4_en   <= en_next;
    end
    if (s4_go) begin
      buf_slots <= lay_slots;
      buf_base  <= s4_base;
      buf_en    <= s4_en;
    end
  end

  always_comb begin
    cur              = buf_slots[k];
    sched_valid      = buf_v;
    slot             = buf_base + SLOT_W'(k);
    first_wait       = cur.wait_ticks;
    first_mask       = cur.mask_a;
    second_wait      = cur.delay_units;
    second_mask      = cur.mask_b;
    enabled_channels = buf_en;
    last             = (k == K_LAST);
  end

  // buffer is only reloaded once its last word has gone
  `ASSERT_IMPLY(a_buf_no_overwrite, s4_go && buf_v, buf_done)
  // word index stays within the five slots
  `ASSERT_IMPLY(a_k_range, buf_v, k <= K_LAST)
  // word index only moves on an accepted word
  `ASSERT_NEXT(a_k_hold, buf_v && sched_stall, k == $past(k))
  // stored enable follows the write
  `ASSERT_NEXT(a_en_written, s3_go, chan_en[$past(s3_ch)] == $past(s3_en))

endmodule
